// File: rtl/core/rbb_pkg.sv
// shared types and constants of the rgb box blur filter
package rbb_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_RADIUS = 3;
  localparam int MAX_HEIGHT     = 4096;
  localparam int QBITS          = 8;

  localparam logic [10:0] RST_WIDTH  = 11'd640;
  localparam logic [12:0] RST_HEIGHT = 13'd480;
  localparam logic [1:0]  RST_RADIUS = 2'd2;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_RADIUS = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_SUMEND,
    ST_DIVGO,
    ST_DIV,
    ST_PASS,
    ST_PCAP,
    ST_LOAD
  } blur_state_t;

endpackage

// File: rtl/core/rgb_box_blur_filter.sv
// sequence: a transaction that releases a blurred result sums the window, then divides,
// a passed-through border result is read and captured; transactions that release nothing stay idle
// throughput: one item at a time, set by the single read port of the line store
// that walks the window one pixel a cycle, then the eight-cell divider chain
// reset: synchronous active-low rst_n clears counters, drain flag and handshakes,
// registers return to 640 x 480 radius 2; the line store is not cleared
module rgb_box_blur_filter #(
  parameter int MAX_WIDTH  = rbb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_RADIUS = rbb_pkg::DEF_MAX_RADIUS
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // in_blue, in_green, in_red
  input  logic        in_tuser,   // operation: 0 pixel, 1 flush
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // blue, green, red result bytes
  output logic        out_tlast,  // frame_end
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rbb_pkg::*;

  localparam int CW       = $clog2(MAX_WIDTH);
  localparam int EW       = CW + 1;
  localparam int SB       = $clog2(2*MAX_RADIUS+2);
  localparam int AW       = SB + CW;
  localparam int DEPTH    = 1 << AW;
  localparam int WIN      = 2*MAX_RADIUS + 1;
  localparam int OW       = $clog2(WIN);
  localparam int AREA_MAX = WIN * WIN;
  localparam int AREA_W   = $clog2(AREA_MAX + 1);
  localparam int SUM_W    = $clog2(255*AREA_MAX + 1);
  localparam int KW       = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int RWD      = $clog2(MAX_HEIGHT);

  // configuration registers
  logic [10:0] width_r;
  logic [12:0] height_r;
  logic [1:0]  radius_r;
  reg_idx_t    cfg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (cfg_idx)
      REG_WIDTH:  prdata = 32'(width_r);
      REG_HEIGHT: prdata = 32'(height_r);
      REG_RADIUS: prdata = 32'(radius_r);
      default:    prdata = '0;
    endcase
  end

  // effective, clamped frame geometry
  logic [EW-1:0]     w_eff;
  logic [12:0]       h_eff;
  logic [1:0]        r_eff;
  logic [AREA_W-1:0] area;
  logic [KW-1:0]     delay;
  logic [2:0]        rw1;

  always_comb begin
    if (width_r == '0)                   w_eff = EW'(1);
    else if (13'(width_r) > 13'(MAX_WIDTH)) w_eff = EW'(MAX_WIDTH);
    else                                 w_eff = EW'(width_r);
    if (height_r == '0)                  h_eff = 13'd1;
    else if (height_r > 13'(MAX_HEIGHT)) h_eff = 13'(MAX_HEIGHT);
    else                                 h_eff = height_r;
    if (32'(radius_r) > MAX_RADIUS)      r_eff = 2'(MAX_RADIUS);
    else                                 r_eff = radius_r;
  end

  assign rw1   = {r_eff, 1'b1};
  assign area  = AREA_W'(rw1) * AREA_W'(rw1);
  assign delay = KW'(r_eff) * KW'(w_eff) + KW'(r_eff);

  // stream position state
  logic [RWD-1:0] in_row_r, out_row_r;
  logic [CW-1:0]  in_col_r, out_col_r;
  logic [KW-1:0]  k_r;
  logic           draining_r;

  blur_state_t st_r, st_nxt;

  logic in_acc, is_flush, win_in, emit_now, load_ok, last_px;
  logic div_go, div_out_valid;
  logic [2:0][QBITS-1:0] div_q;

  assign in_acc   = in_tvalid && in_tready;
  assign is_flush = in_tuser;
  assign emit_now = is_flush ? draining_r : (!draining_r && (k_r >= delay));

  assign win_in = (14'(out_row_r) >= 14'(r_eff)) && (14'(out_col_r) >= 14'(r_eff)) &&
                  (14'(out_row_r) + 14'(r_eff) < 14'(h_eff)) &&
                  (14'(out_col_r) + 14'(r_eff) < 14'(w_eff));

  assign last_px = (14'(out_row_r) + 14'd1 >= 14'(h_eff)) &&
                   (14'(out_col_r) + 14'd1 >= 14'(w_eff));

  // window walk
  logic [OW-1:0] dr_r, dc_r, wmax;
  assign wmax = OW'({r_eff, 1'b0});

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (in_acc && emit_now) st_nxt = win_in ? ST_SUM : ST_PASS;
      end
      ST_SUM: begin
        if (dc_r == wmax && dr_r == wmax) st_nxt = ST_SUMEND;
      end
      ST_SUMEND: st_nxt = ST_DIVGO;
      ST_DIVGO:  st_nxt = ST_DIV;
      ST_DIV: begin
        if (div_out_valid) st_nxt = ST_LOAD;
      end
      ST_PASS: st_nxt = ST_PCAP;
      ST_PCAP: st_nxt = ST_LOAD;
      ST_LOAD: begin
        if (!out_tvalid || out_tready) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready = 1'b0;
    div_go    = 1'b0;
    load_ok   = 1'b0;
    case (st_r)
      ST_IDLE:  in_tready = 1'b1;
      ST_DIVGO: div_go    = 1'b1;
      ST_LOAD:  load_ok   = !out_tvalid || out_tready;
      default:  ;
    endcase
  end

  // line store, one write and one registered read port
  logic [23:0]    mem [DEPTH];
  logic [23:0]    rd_data_r;
  logic [AW-1:0]  wr_addr, rd_addr;
  logic [RWD-1:0] rd_row;
  logic [CW-1:0]  rd_col;
  logic           mem_we;

  assign mem_we  = in_acc && !is_flush && !draining_r;
  assign wr_addr = {in_row_r[SB-1:0], in_col_r};
  assign rd_row  = out_row_r - RWD'(r_eff) + RWD'(dr_r);
  assign rd_col  = out_col_r - CW'(r_eff) + CW'(dc_r);
  assign rd_addr = {rd_row[SB-1:0], rd_col};

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= in_tdata;
    rd_data_r <= mem[rd_addr];
  end

  // window sums
  logic [2:0][SUM_W-1:0] sum_r;
  logic                  acc_en_r;
  logic [2:0][7:0]       res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_en_r <= 1'b0;
    end else begin
      acc_en_r <= (st_r == ST_SUM);
    end
    if (st_r == ST_IDLE) begin
      sum_r <= '0;
    end else if (acc_en_r) begin
      for (int c = 0; c < 3; c++) sum_r[c] <= sum_r[c] + SUM_W'(rd_data_r[8*c +: 8]);
    end
    if (st_r == ST_PCAP) begin
      for (int c = 0; c < 3; c++) res_r[c] <= rd_data_r[8*c +: 8];
    end else if (st_r == ST_DIV && div_out_valid) begin
      res_r <= div_q;
    end
  end

  rbb_div_chain #(
    .SUM_W (SUM_W),
    .AREA_W(AREA_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (div_go),
    .in_sum   (sum_r),
    .area     (area),
    .out_valid(div_out_valid),
    .out_q    (div_q)
  );

  // output register
  logic [23:0] out_data_r;
  logic        out_last_r;

  always_ff @(posedge clk) begin
    if (load_ok) begin
      out_data_r <= {res_r[2], res_r[1], res_r[0]};
      out_last_r <= last_px;
    end
  end

  assign out_tdata = out_data_r;
  assign out_tlast = out_last_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      width_r    <= RST_WIDTH;
      height_r   <= RST_HEIGHT;
      radius_r   <= RST_RADIUS;
      in_row_r   <= '0;
      in_col_r   <= '0;
      out_row_r  <= '0;
      out_col_r  <= '0;
      k_r        <= '0;
      draining_r <= 1'b0;
      dr_r       <= '0;
      dc_r       <= '0;
      out_tvalid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      // a new result replaces the one leaving in the same cycle
      if (load_ok) out_tvalid <= 1'b1;
      else if (out_tvalid && out_tready) out_tvalid <= 1'b0;

      if (cfg_wr && cfg_idx != REG_NONE) begin
        case (cfg_idx)
          REG_WIDTH:  width_r  <= pwdata[10:0];
          REG_HEIGHT: height_r <= pwdata[12:0];
          REG_RADIUS: radius_r <= pwdata[1:0];
          default:    ;
        endcase
        // a register write restarts the frame
        in_row_r   <= '0;
        in_col_r   <= '0;
        out_row_r  <= '0;
        out_col_r  <= '0;
        k_r        <= '0;
        draining_r <= 1'b0;
      end else begin
        // pixel arrival: advance input raster position
        if (mem_we) begin
          k_r <= k_r + KW'(1);
          if (EW'(in_col_r) + EW'(1) >= w_eff) begin
            in_col_r <= '0;
            if (13'(in_row_r) + 13'd1 >= h_eff) begin
              in_row_r   <= '0;
              draining_r <= 1'b1;
            end else begin
              in_row_r <= in_row_r + RWD'(1);
            end
          end else begin
            in_col_r <= in_col_r + CW'(1);
          end
        end
        // result leaves: advance output position or end the frame
        if (load_ok) begin
          if (last_px) begin
            in_row_r   <= '0;
            in_col_r   <= '0;
            out_row_r  <= '0;
            out_col_r  <= '0;
            k_r        <= '0;
            draining_r <= 1'b0;
          end else if (EW'(out_col_r) + EW'(1) >= w_eff) begin
            out_col_r <= '0;
            out_row_r <= out_row_r + RWD'(1);
          end else begin
            out_col_r <= out_col_r + CW'(1);
          end
        end
      end

      // window walk offsets; border pixels read their own spot
      if (st_r == ST_IDLE) begin
        dr_r <= win_in ? '0 : OW'(r_eff);
        dc_r <= win_in ? '0 : OW'(r_eff);
      end else if (st_r == ST_SUM) begin
        if (dc_r == wmax) begin
          dc_r <= '0;
          if (dr_r != wmax) dr_r <= dr_r + OW'(1);
        end else begin
          dc_r <= dc_r + OW'(1);
        end
      end
    end
  end

  // checks
  a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_out_valid |-> st_r == ST_DIV)
    else $error("divider result outside of wait state");

  a_load_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_LOAD && out_tvalid && !out_tready) |=> st_r == ST_LOAD)
    else $error("result loaded over a pending transaction");

  a_drain_pos: assert property (@(posedge clk) disable iff (!rst_n)
    draining_r |-> (in_row_r == '0 && in_col_r == '0))
    else $error("input position moved while draining");

endmodule

// File: rtl/core/rbb_div_cell.sv
// one restoring division step for three channels, registered
module rbb_div_cell #(
  parameter int SUM_W  = 14,
  parameter int AREA_W = 6,
  parameter int SHIFT  = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [2:0][SUM_W-1:0]  in_rem,
  input  logic [2:0][rbb_pkg::QBITS-1:0] in_q,
  input  logic [AREA_W-1:0]      area,
  output logic                   out_valid,
  output logic [2:0][SUM_W-1:0]  out_rem,
  output logic [2:0][rbb_pkg::QBITS-1:0] out_q
);
  import rbb_pkg::*;

  logic [SUM_W+QBITS-1:0] dv;
  logic [2:0][SUM_W-1:0]  rem_nxt;
  logic [2:0][QBITS-1:0]  q_nxt;
  logic                   valid_r;
  logic [2:0][SUM_W-1:0]  rem_r;
  logic [2:0][QBITS-1:0]  q_r;

  assign dv = (SUM_W+QBITS)'(area) << SHIFT;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if ((SUM_W+QBITS)'(in_rem[c]) >= dv) begin
        rem_nxt[c] = in_rem[c] - dv[SUM_W-1:0];
        q_nxt[c]   = {in_q[c][QBITS-2:0], 1'b1};
      end else begin
        rem_nxt[c] = in_rem[c];
        q_nxt[c]   = {in_q[c][QBITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_q     = q_r;
endmodule

// File: rtl/core/rbb_div_chain.sv
// row of division cells, one quotient bit per cell
module rbb_div_chain #(
  parameter int SUM_W  = 14,
  parameter int AREA_W = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [2:0][SUM_W-1:0] in_sum,
  input  logic [AREA_W-1:0]     area,
  output logic                  out_valid,
  output logic [2:0][rbb_pkg::QBITS-1:0] out_q
);
  import rbb_pkg::*;

  logic [QBITS:0]                     v;
  logic [QBITS:0][2:0][SUM_W-1:0]     rem;
  logic [QBITS:0][2:0][QBITS-1:0]     q;

  assign v[0]   = in_valid;
  assign rem[0] = in_sum;
  assign q[0]   = '0;

  for (genvar k = 0; k < QBITS; k++) begin : g_cell
    rbb_div_cell #(
      .SUM_W (SUM_W),
      .AREA_W(AREA_W),
      .SHIFT (QBITS-1-k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (v[k]),
      .in_rem   (rem[k]),
      .in_q     (q[k]),
      .area     (area),
      .out_valid(v[k+1]),
      .out_rem  (rem[k+1]),
      .out_q    (q[k+1])
    );
  end

  assign out_valid = v[QBITS];
  assign out_q     = q[QBITS];
endmodule

// File: tb/tb.sv
// self-checking testbench of the rgb box blur filter
module tb;
  import rbb_pkg::*;

  localparam int PRED_W  = 1024;
  localparam int PRED_R  = 3;
  localparam int SLOTS   = 2 * PRED_R + 2;
  localparam int RUN_GAP = 60;  // cycles to settle before a register write

  typedef struct packed {
    logic       flush;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_item_t;

  typedef struct packed {
    logic       frame_end;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } blur_pixel_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // blue, green, red
  logic        in_tuser;   // operation
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // blue, green, red
  logic        out_tlast;  // frame_end
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rgb_box_blur_filter uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // predictor state, a copy of the block's registers and line buffer
  logic [23:0] rows_mem [SLOTS][PRED_W];
  logic [10:0] cfg_width;
  logic [12:0] cfg_height;
  logic [1:0]  cfg_radius;
  int          pin_row, pin_col, pout_row, pout_col;
  bit          drain_mode;

  pixel_item_t pixel_queue[$];
  blur_pixel_t blur_expected[$];
  int          fail_count;
  bit          stim_done;
  int          hold_cycles;   // long receiver hold-off, counted down by the monitor
  bit          drive_paused;
  bit          in_taken;      // input transaction accepted at the last rising edge

  function automatic int eff_width();
    if (cfg_width == 0) return 1;
    if (cfg_width > PRED_W) return PRED_W;
    return cfg_width;
  endfunction

  function automatic int eff_height();
    if (cfg_height == 0) return 1;
    if (cfg_height > MAX_HEIGHT) return MAX_HEIGHT;
    return cfg_height;
  endfunction

  function automatic int eff_radius();
    return (cfg_radius > PRED_R) ? PRED_R : cfg_radius;
  endfunction

  function automatic void restart_frame();
    pin_row = 0; pin_col = 0; pout_row = 0; pout_col = 0;
    drain_mode = 0;
  endfunction

  // produce the next output pixel in raster order
  function automatic blur_pixel_t next_blur_pixel();
    int w, h, r, area, sb, sg, sr;
    logic [23:0] p;
    blur_pixel_t res;
    w = eff_width(); h = eff_height(); r = eff_radius();
    if (pout_row >= r && pout_col >= r && pout_row + r < h && pout_col + r < w) begin
      area = (2 * r + 1) * (2 * r + 1);
      sb = 0; sg = 0; sr = 0;
      for (int rr = pout_row - r; rr <= pout_row + r; rr++)
        for (int cc = pout_col - r; cc <= pout_col + r; cc++) begin
          p = rows_mem[rr % SLOTS][cc % PRED_W];
          sb += p[7:0]; sg += p[15:8]; sr += p[23:16];
        end
      res.blue = 8'(sb / area); res.green = 8'(sg / area); res.red = 8'(sr / area);
    end else begin
      p = rows_mem[pout_row % SLOTS][pout_col % PRED_W];
      res.blue = p[7:0]; res.green = p[15:8]; res.red = p[23:16];
    end
    res.frame_end = (pout_row + 1 >= h) && (pout_col + 1 >= w);
    if (res.frame_end) restart_frame();
    else begin
      pout_col++;
      if (pout_col >= w) begin
        pout_col = 0; pout_row++;
      end
    end
    return res;
  endfunction

  // advance the predictor by one accepted transaction
  function automatic void predict_blur(pixel_item_t it);
    int w, h, r, k;
    w = eff_width(); h = eff_height(); r = eff_radius();
    if (it.flush) begin
      if (drain_mode) blur_expected.push_back(next_blur_pixel());
      return;
    end
    if (drain_mode) return;
    k = pin_row * w + pin_col;
    rows_mem[pin_row % SLOTS][pin_col % PRED_W] = {it.red, it.green, it.blue};
    pin_col++;
    if (pin_col >= w) begin
      pin_col = 0; pin_row++;
      if (pin_row >= h) begin
        pin_row = 0; drain_mode = 1;
      end
    end
    if (k >= r * w + r) blur_expected.push_back(next_blur_pixel());
  endfunction

  // driver: one item from the queue, random gaps between transactions
  int in_gap;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap = 0;
    end else if (in_tvalid && !in_taken) begin
      // hold current transaction
    end else if (in_gap > 0) begin
      in_tvalid <= 1'b0;
      in_gap--;
    end else if (pixel_queue.size() > 0 && !drive_paused) begin
      pixel_item_t it;
      it = pixel_queue.pop_front();
      in_tvalid <= 1'b1;
      in_tuser  <= it.flush;
      in_tdata  <= {it.red, it.green, it.blue};
      if ($urandom_range(0, 2) == 0)
        in_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // predictor fed on every accepted input transaction
  always @(posedge clk) begin
    in_taken = rst_n && in_tvalid && in_tready;
    if (in_taken)
      predict_blur('{flush: in_tuser, red: in_tdata[23:16], green: in_tdata[15:8],
                     blue: in_tdata[7:0]});
  end

  // monitor: checks results and drives out_tready with random stalls
  int out_gap;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (blur_expected.size() == 0) begin
        $error("unexpected result transaction %h", out_tdata);
        fail_count++;
      end else begin
        blur_pixel_t e;
        e = blur_expected.pop_front();
        if (out_tdata[7:0] !== e.blue) begin
          $error("blurred blue expected %0d actual %0d", e.blue, out_tdata[7:0]);
          fail_count++;
        end
        if (out_tdata[15:8] !== e.green) begin
          $error("blurred green expected %0d actual %0d", e.green, out_tdata[15:8]);
          fail_count++;
        end
        if (out_tdata[23:16] !== e.red) begin
          $error("blurred red expected %0d actual %0d", e.red, out_tdata[23:16]);
          fail_count++;
        end
        if (out_tlast !== e.frame_end) begin
          $error("frame_end expected %0d actual %0d", e.frame_end, out_tlast); fail_count++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap = 0;
    end else if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles--;
    end else if (out_gap > 0) begin
      out_tready <= 1'b0;
      out_gap--;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0)
        out_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
    end
  end

  // wait until every queued item went in and every expected result came out
  task automatic wait_drained();
    while (pixel_queue.size() > 0 || in_tvalid || blur_expected.size() > 0)
      @(posedge clk);
    repeat (RUN_GAP) @(posedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 4'(idx) << 2; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_WIDTH:  cfg_width  = value[10:0];
      REG_HEIGHT: cfg_height = value[12:0];
      REG_RADIUS: cfg_radius = value[1:0];
      default: ;
    endcase
    restart_frame();
  endtask

  function automatic pixel_item_t rand_pixel();
    pixel_item_t it;
    it.flush = 1'b0;
    it.blue = $urandom; it.green = $urandom; it.red = $urandom;
    return it;
  endfunction

  function automatic void push_flush();
    pixel_item_t it;
    it = rand_pixel();
    it.flush = 1'b1;
    pixel_queue.push_back(it);
  endfunction

  // one whole frame of w*h pixels followed by its drain flushes
  task automatic queue_frame(int w, int h, int r, bit noisy);
    int npix, nflush;
    npix = w * h;
    nflush = (npix < r * w + r) ? npix : r * w + r;
    for (int i = 0; i < npix; i++) begin
      pixel_queue.push_back(rand_pixel());
      if (noisy && $urandom_range(0, 15) == 0) push_flush();  // ignored mid-frame
    end
    if (noisy && $urandom_range(0, 1) == 0) pixel_queue.push_back(rand_pixel()); // ignored
    for (int i = 0; i < nflush; i++) push_flush();
  endtask

  task automatic set_frame(int w, int h, int r);
    wait_drained();
    cfg_write(REG_WIDTH, w);
    cfg_write(REG_HEIGHT, h);
    cfg_write(REG_RADIUS, r);
  endtask

  initial begin
    int sent;
    pixel_item_t it;
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; in_tuser = 1'b0; out_tready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    fail_count = 0; stim_done = 0; hold_cycles = 0; drive_paused = 0; in_taken = 0;
    cfg_width = RST_WIDTH; cfg_height = RST_HEIGHT; cfg_radius = RST_RADIUS;
    restart_frame();
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // flush when idle is ignored
    push_flush();
    // directed: 3x3 frame, radius 1, channel extremes
    set_frame(3, 3, 1);
    // receiver stalls long while the pixels keep coming, input backs up
    hold_cycles = 300;
    for (int i = 0; i < 9; i++) begin
      it.flush = 0;
      it.blue = (i % 2) ? 8'hFF : 8'h00; it.green = 8'hFF; it.red = (i == 4) ? 8'h00 : 8'hFF;
      pixel_queue.push_back(it);
    end
    pixel_queue.push_back(rand_pixel());  // pixel while draining is ignored
    for (int i = 0; i < 4; i++) push_flush();
    // frame smaller than the window passes through
    set_frame(2, 2, 3);
    queue_frame(2, 2, 3, 0);
    // single pixel frame with out-of-range zero size
    set_frame(0, 0, 0);
    queue_frame(1, 1, 0, 0);

    // random frames, small sizes mostly, extremes now and then
    sent = 0;
    while (sent < 1450) begin
      int w, h, r, wc, hc, npix;
      r = $urandom_range(0, 3);
      case ($urandom_range(0, 9))
        0: begin w = 1024 + $urandom_range(0, 1); h = 1; end        // widest row, clamp
        1: begin w = $urandom_range(1, 3); h = 4096 + $urandom_range(0, 1) * 4000; end
        default: begin w = $urandom_range(1, 12); h = $urandom_range(1, 12); end
      endcase
      if (h > 4096 && w * 4096 > 4000) h = 2;
      if (w * (h > 4096 ? 4096 : h) > 3000) h = 1;
      // a wide row only early on and without flushes, to keep the item count
      if (w >= 1024) begin
        r = 0;
        if (sent + 1024 > 1450) w = $urandom_range(1, 12);
      end
      set_frame(w, h, r);
      if ($urandom_range(0, 7) == 0) begin
        // receiver stalls long while input keeps coming
        hold_cycles = 300;
      end
      wc = (w > 1024) ? 1024 : w;
      hc = (h > 4096) ? 4096 : h;
      queue_frame(wc, hc, r, 1);
      npix = wc * hc;
      sent += npix + ((npix < r * wc + r) ? npix : r * wc + r);
      // broken frame: cut off then restarted by a register write
      if ($urandom_range(0, 9) == 0) begin
        wait_drained();
        for (int i = 0; i < 5; i++) pixel_queue.push_back(rand_pixel());
        sent += 5;
      end
    end
    // register values that only hit the masks and the top of the fields
    set_frame(32'hFFFF_F7FF, 32'h0000_1FFF, 3);
    cfg_write(REG_RADIUS, 32'hFFFF_FFFC);
    for (int i = 0; i < 40; i++) pixel_queue.push_back(rand_pixel());
    wait_drained();
    stim_done = 1;
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #20000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: rgb_box_blur_filter.f
rtl/core/rbb_pkg.sv
rtl/core/rbb_div_cell.sv
rtl/core/rbb_div_chain.sv
rtl/core/rgb_box_blur_filter.sv
tb/tb.sv
